// ===== rtl/tvt_pkg.sv =====
// ----------------------------------------------------------------------------
// tvt_pkg
// shared types, register codes and constants of the thermistor converter
// ----------------------------------------------------------------------------
package tvt_pkg;

  localparam int LOG_STEPS   = 28;
  localparam int LOG_LAT     = LOG_STEPS + 1;
  localparam int HORNER_LAT  = 2;
  localparam int RECIP_BITS  = 17;
  localparam int RECIP_LAT   = RECIP_BITS + 1;
  localparam int PIPE_LAT    = LOG_LAT + 2 + 3 * HORNER_LAT + RECIP_LAT;

  localparam logic [4:0]  SIDE_A_CHANNELS = 5'd9;
  localparam logic [31:0] LN2_Q32         = 32'hB17217F8;
  localparam logic [61:0] MAG_CAP         = {62{1'b1}};
  localparam logic [62:0] RECIP_NUM       = 63'd100 << 50;
  localparam logic signed [17:0] CK_OFFSET = 18'sd27315;
  localparam logic signed [15:0] TEMP_MAX  = 16'sd32767;
  localparam logic signed [15:0] TEMP_MIN  = -16'sd27315;

  localparam logic [2:0] REG_SUPPLY = 3'd0;
  localparam logic [2:0] REG_COEF_A = 3'd1;
  localparam logic [2:0] REG_COEF_B = 3'd2;
  localparam logic [2:0] REG_COEF_C = 3'd3;
  localparam logic [2:0] REG_COEF_D = 3'd4;

  localparam logic [15:0] SUPPLY_RST = 16'd33000;
  localparam logic signed [47:0] COEF_A_RST = 48'sd3776286300000;
  localparam logic signed [47:0] COEF_B_RST = 48'sd289339500000;
  localparam logic signed [47:0] COEF_C_RST = 48'sd2949989000;
  localparam logic signed [47:0] COEF_D_RST = 48'sd71867270;

  typedef struct packed {
    logic [15:0] sample_voltage;
    logic [4:0]  channel;
    logic [15:0] ref_side_a;
    logic [15:0] ref_side_b;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [4:0]         channel_out;
    logic               board_sensor;
    logic               fault;
  } out_req_t;

  typedef struct packed {
    logic [4:0] channel;
    logic       board;
    logic       fault;
  } side_t;

  typedef struct packed {
    logic zero;
    logic neg;
    logic sat;
  } recip_flag_t;

endpackage

// ===== rtl/tvt_log2.sv =====
// ----------------------------------------------------------------------------
// tvt_log2
// pipelined base-2 log of a 16 bit integer, q.28, one fraction bit per stage
// ----------------------------------------------------------------------------
module tvt_log2 (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] n,
  output logic [31:0] lg
);

  localparam int STEPS = tvt_pkg::LOG_STEPS;

  logic [30:0]      m_r [0:STEPS];
  logic [3:0]       e_r [0:STEPS];
  logic [STEPS-1:0] f_r [0:STEPS];
  logic [3:0]       e_nxt;

  always_comb begin
    e_nxt = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (n[i]) begin
        e_nxt = 4'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= e_nxt;
      m_r[0] <= 31'(n) << (5'd30 - {1'b0, e_nxt});
      f_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [61:0] sq;
    logic [31:0] t;
    assign sq = 62'(m_r[k-1]) * 62'(m_r[k-1]);
    assign t  = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        e_r[k] <= e_r[k-1];
        f_r[k] <= f_r[k-1] | (STEPS'(t[31]) << (STEPS - k));
        m_r[k] <= t[31] ? t[31:1] : t[30:0];
      end
    end
  end

  assign lg = {e_r[STEPS], f_r[STEPS]};

endmodule

// ===== rtl/tvt_horner.sv =====
// ----------------------------------------------------------------------------
// tvt_horner
// one horner step: t * x in q.28 with magnitude clamp, plus coefficient
// ----------------------------------------------------------------------------
module tvt_horner (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] t_in,
  input  logic [31:0]        x_mag_in,
  input  logic               x_neg_in,
  input  logic signed [47:0] coef,
  output logic signed [63:0] t_out,
  output logic [31:0]        x_mag_out,
  output logic               x_neg_out
);

  logic [63:0] ua;
  logic [63:0] p0_r, p1_r;
  logic        neg_r;
  logic [31:0] xa_r;
  logic        xn_r;
  logic [95:0] full;
  logic [67:0] sh;
  logic [61:0] r;
  logic signed [63:0] sp;
  logic signed [63:0] t_r;
  logic [31:0] xb_r;
  logic        xnb_r;

  assign ua = t_in[63] ? 64'(-t_in) : 64'(t_in);

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r  <= 64'(ua[31:0]) * 64'(x_mag_in);
      p1_r  <= 64'(ua[63:32]) * 64'(x_mag_in);
      neg_r <= t_in[63] ^ x_neg_in;
      xa_r  <= x_mag_in;
      xn_r  <= x_neg_in;
    end
  end

  always_comb begin
    full = {p1_r, 32'd0} + {32'd0, p0_r};
    sh   = full[95:28];
    r    = (sh[67:62] != 6'd0) ? tvt_pkg::MAG_CAP : sh[61:0];
    sp   = neg_r ? -$signed({2'b00, r}) : $signed({2'b00, r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r   <= sp + {{16{coef[47]}}, coef};
      xb_r  <= xa_r;
      xnb_r <= xn_r;
    end
  end

  assign t_out     = t_r;
  assign x_mag_out = xb_r;
  assign x_neg_out = xnb_r;

endmodule

// ===== rtl/tvt_recip.sv =====
// ----------------------------------------------------------------------------
// tvt_recip
// pipelined restoring divider for the centikelvin reciprocal, one bit a stage
// ----------------------------------------------------------------------------
module tvt_recip (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [63:0]           s,
  output logic [tvt_pkg::RECIP_BITS-1:0] q,
  output tvt_pkg::recip_flag_t         flag
);

  localparam int QB = tvt_pkg::RECIP_BITS;

  logic [62:0] us;
  logic [62:0] num;
  logic [62:0] num_hi;

  logic [63:0]  r_r  [0:QB];
  logic [62:0]  d_r  [0:QB];
  logic [QB-1:0] nl_r [0:QB];
  logic [QB-1:0] q_r  [0:QB];
  tvt_pkg::recip_flag_t fl_r [0:QB];

  always_comb begin
    us     = s[62:0];
    num    = tvt_pkg::RECIP_NUM + {1'b0, us[62:1]};
    num_hi = num >> QB;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]       <= {1'b0, num_hi};
      d_r[0]       <= us;
      nl_r[0]      <= num[QB-1:0];
      q_r[0]       <= '0;
      fl_r[0].zero <= (s == 64'sd0);
      fl_r[0].neg  <= s[63];
      fl_r[0].sat  <= (num_hi >= us);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [63:0] rr;
    logic        ge;
    assign rr = {r_r[k-1][62:0], nl_r[k-1][QB-k]};
    assign ge = rr >= {1'b0, d_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]  <= ge ? rr - {1'b0, d_r[k-1]} : rr;
        d_r[k]  <= d_r[k-1];
        nl_r[k] <= nl_r[k-1];
        fl_r[k] <= fl_r[k-1];
        q_r[k]  <= q_r[k-1] | (QB'(ge) << (QB - k));
      end
    end
  end

  assign q    = q_r[QB];
  assign flag = fl_r[QB];

endmodule

// ===== rtl/thermistor_voltage_to_temperature_core.sv =====
// ----------------------------------------------------------------------------
// thermistor_voltage_to_temperature_core
// ntc divider voltage to temperature: log ratio, cubic polynomial, reciprocal
// ----------------------------------------------------------------------------
// pipeline: the request enters the first of 57 register stages at the accept
//   edge, the output register is the last, and the depth is set mostly by the
//   28 log and 17 divider stages
// throughput: one request per cycle; a stalled output holds the whole pipeline
// reset: synchronous active low, clears valid bits and loads register defaults
// ----------------------------------------------------------------------------
module thermistor_voltage_to_temperature_core #(
  parameter logic [4:0] SIDE_A_CHANNELS = tvt_pkg::SIDE_A_CHANNELS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tvt_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tvt_pkg::out_req_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [47:0]       cfg_wdata
);

  localparam int PL = tvt_pkg::PIPE_LAT;

  logic        en;
  logic [15:0] supply_r;
  logic signed [47:0] coef_a_r, coef_b_r, coef_c_r, coef_d_r;

  logic          vld_r  [0:PL];
  tvt_pkg::side_t side_r [0:PL];
  tvt_pkg::side_t side_nxt;
  logic [15:0]   vref;
  logic [15:0]   n1_r, n2_r;

  logic [31:0] l1, l2;
  logic [31:0] dm_r;
  logic        dn_r;
  logic [64:0] xsum;
  logic [31:0] xm_r;
  logic        xn_r;

  logic signed [63:0] t1, t2, t3;
  logic [31:0] x1m, x2m, x3m;
  logic        x1n, x2n, x3n;

  logic [tvt_pkg::RECIP_BITS-1:0] q;
  tvt_pkg::recip_flag_t flag;
  logic signed [17:0] tq;
  logic signed [15:0] temp_nxt;

  logic              out_valid_r;
  tvt_pkg::out_req_t out_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= tvt_pkg::SUPPLY_RST;
      coef_a_r <= tvt_pkg::COEF_A_RST;
      coef_b_r <= tvt_pkg::COEF_B_RST;
      coef_c_r <= tvt_pkg::COEF_C_RST;
      coef_d_r <= tvt_pkg::COEF_D_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tvt_pkg::REG_SUPPLY: supply_r <= cfg_wdata[15:0];
        tvt_pkg::REG_COEF_A: coef_a_r <= cfg_wdata;
        tvt_pkg::REG_COEF_B: coef_b_r <= cfg_wdata;
        tvt_pkg::REG_COEF_C: coef_c_r <= cfg_wdata;
        tvt_pkg::REG_COEF_D: coef_d_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // reference select and fault check
  always_comb begin
    side_nxt.channel = in_data.channel;
    side_nxt.board   = (in_data.ref_side_a != 16'd0) && (in_data.ref_side_b != 16'd0);
    if (side_nxt.board) begin
      vref = (in_data.channel < SIDE_A_CHANNELS) ? in_data.ref_side_a
                                                 : in_data.ref_side_b;
    end else begin
      vref = supply_r;
    end
    side_nxt.fault = (in_data.sample_voltage == 16'd0) || (in_data.sample_voltage >= vref);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      n1_r      <= in_data.sample_voltage;
      n2_r      <= vref - in_data.sample_voltage;
      for (int i = 1; i <= PL; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= PL; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i <= PL; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  tvt_log2 u_log_v (.clk(clk), .en(en), .n(n1_r), .lg(l1));
  tvt_log2 u_log_r (.clk(clk), .en(en), .n(n2_r), .lg(l2));

  // log ratio times ln 2
  assign xsum = {1'b0, 64'(dm_r) * 64'(tvt_pkg::LN2_Q32)} + 65'h80000000;

  always_ff @(posedge clk) begin
    if (en) begin
      dm_r <= (l1 >= l2) ? l1 - l2 : l2 - l1;
      dn_r <= l1 < l2;
      xm_r <= xsum[63:32];
      xn_r <= dn_r;
    end
  end

  tvt_horner u_h_c (
    .clk(clk), .en(en), .t_in({{16{coef_d_r[47]}}, coef_d_r}),
    .x_mag_in(xm_r), .x_neg_in(xn_r), .coef(coef_c_r),
    .t_out(t1), .x_mag_out(x1m), .x_neg_out(x1n)
  );

  tvt_horner u_h_b (
    .clk(clk), .en(en), .t_in(t1), .x_mag_in(x1m), .x_neg_in(x1n), .coef(coef_b_r),
    .t_out(t2), .x_mag_out(x2m), .x_neg_out(x2n)
  );

  tvt_horner u_h_a (
    .clk(clk), .en(en), .t_in(t2), .x_mag_in(x2m), .x_neg_in(x2n), .coef(coef_a_r),
    .t_out(t3), .x_mag_out(x3m), .x_neg_out(x3n)
  );

  tvt_recip u_recip (.clk(clk), .en(en), .s(t3), .q(q), .flag(flag));

  // centikelvin to centidegree with saturation
  always_comb begin
    tq = $signed({1'b0, q}) - tvt_pkg::CK_OFFSET;
    priority if (side_r[PL].fault) begin
      temp_nxt = 16'sd0;
    end else if (flag.zero || flag.sat) begin
      temp_nxt = tvt_pkg::TEMP_MAX;
    end else if (flag.neg) begin
      temp_nxt = tvt_pkg::TEMP_MIN;
    end else if (tq > 18'sd32767) begin
      temp_nxt = tvt_pkg::TEMP_MAX;
    end else begin
      temp_nxt = tq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[PL];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.temperature  <= temp_nxt;
      out_r.channel_out  <= side_r[PL].channel;
      out_r.board_sensor <= side_r[PL].board;
      out_r.fault        <= side_r[PL].fault;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the thermistor converter against a bit-exact predictor of the log
// ratio, cubic polynomial and reciprocal, under random idling and stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tvt_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tvt_pkg::out_req_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_wdata = '0;

  thermistor_voltage_to_temperature_core uut (.*);

  always #5 clk = ~clk;

  logic [15:0] supply;
  logic signed [47:0] coef [4];

  tvt_pkg::in_req_t pending_q [$];
  tvt_pkg::out_req_t temp_q [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int results = 0;
  int faults = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] log2_q28(logic [15:0] n);
    int e;
    logic [63:0] m;
    logic [63:0] frac;
    e = 15;
    frac = '0;
    while (e > 0 && !n[e]) e--;
    m = 64'(n) << (30 - e);
    for (int i = 27; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        frac[i] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(e) << 28) | frac;
  endfunction

  function automatic logic signed [63:0] scale_q28(logic signed [63:0] t,
                                                   logic signed [63:0] x);
    logic [127:0] p;
    logic [63:0] r;
    p = 128'(t < 0 ? -t : t) * 128'(x < 0 ? -x : x);
    p = p >> 28;
    r = (p > 128'(tvt_pkg::MAG_CAP)) ? 64'(tvt_pkg::MAG_CAP) : p[63:0];
    return ((t < 0) != (x < 0)) ? -$signed(r) : $signed(r);
  endfunction

  function automatic tvt_pkg::out_req_t convert(tvt_pkg::in_req_t r);
    tvt_pkg::out_req_t o;
    logic [15:0] vref;
    logic signed [63:0] d, x, s;
    logic [63:0] xm, q;
    logic signed [63:0] t;
    o.channel_out = r.channel;
    o.board_sensor = (r.ref_side_a != 0) && (r.ref_side_b != 0);
    vref = o.board_sensor ? (r.channel < tvt_pkg::SIDE_A_CHANNELS ? r.ref_side_a
                                                                  : r.ref_side_b)
                          : supply;
    o.fault = (r.sample_voltage == 0) || (r.sample_voltage >= vref);
    o.temperature = '0;
    if (!o.fault) begin
      d = $signed(log2_q28(r.sample_voltage)) - $signed(log2_q28(vref - r.sample_voltage));
      xm = 64'((128'(d < 0 ? -d : d) * 128'(tvt_pkg::LN2_Q32) + 128'(64'h8000_0000)) >> 32);
      x = d < 0 ? -$signed(xm) : $signed(xm);
      s = 64'(coef[3]);
      s = scale_q28(s, x) + 64'(coef[2]);
      s = scale_q28(s, x) + 64'(coef[1]);
      s = scale_q28(s, x) + 64'(coef[0]);
      if (s == 0) o.temperature = tvt_pkg::TEMP_MAX;
      else if (s < 0) o.temperature = tvt_pkg::TEMP_MIN;
      else begin
        q = (64'(tvt_pkg::RECIP_NUM) + 64'(s) / 2) / 64'(s);
        t = $signed(q) - 27315;
        o.temperature = (t > 32767) ? tvt_pkg::TEMP_MAX : 16'(t);
      end
    end
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        temp_q.push_back(convert(in_data));
        void'(pending_q.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results++;
        idle_cycles = 0;
        if (temp_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", out_data);
        end else begin
          tvt_pkg::out_req_t e;
          e = temp_q.pop_front();
          if (out_data.fault) faults++;
          if (e !== out_data) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", e, out_data);
          end
        end
      end else if (!(in_valid && !in_stall)) begin
        idle_cycles++;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
      if (idle_cycles >= LIMIT) begin
        $display("timeout");
        $display("thermistor_voltage_to_temperature_core verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tvt_pkg::REG_SUPPLY: supply = val[15:0];
      tvt_pkg::REG_COEF_A: coef[0] = val;
      tvt_pkg::REG_COEF_B: coef[1] = val;
      tvt_pkg::REG_COEF_C: coef[2] = val;
      tvt_pkg::REG_COEF_D: coef[3] = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || temp_q.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  function automatic tvt_pkg::in_req_t rand_req();
    tvt_pkg::in_req_t r;
    logic [15:0] vr;
    r.channel = $urandom_range(3) == 0 ? 5'($urandom) : 5'($urandom_range(17));
    r.ref_side_a = $urandom_range(9) == 0 ? 16'h0 : 16'($urandom_range(20000, 65535));
    r.ref_side_b = $urandom_range(9) == 0 ? 16'h0 : 16'($urandom_range(20000, 65535));
    vr = (r.ref_side_a != 0 && r.ref_side_b != 0)
         ? (r.channel < tvt_pkg::SIDE_A_CHANNELS ? r.ref_side_a : r.ref_side_b) : supply;
    case ($urandom_range(9))
      0: r.sample_voltage = 16'($urandom);
      1: r.sample_voltage = vr - 16'($urandom_range(2));
      default: r.sample_voltage = 16'($urandom_range(1, vr > 1 ? vr - 1 : 1));
    endcase
    return r;
  endfunction

  task automatic random_phase(int n);
    repeat (n) pending_q.push_back(rand_req());
  endtask

  task automatic directed();
    logic [15:0] vs [10] = '{16'd0, 16'd1, 16'd16500, 16'd32999, 16'd33000,
                             16'd65535, 16'd300, 16'd30000, 16'd8000, 16'd25000};
    foreach (vs[i]) pending_q.push_back('{vs[i], 5'(i), 16'd0, 16'd0});
    pending_q.push_back('{16'd1000, 5'd8, 16'd5000, 16'd40000});
    pending_q.push_back('{16'd10000, 5'd9, 16'd5000, 16'd40000});
    pending_q.push_back('{16'd10000, 5'd31, 16'd65535, 16'd40000});
    pending_q.push_back('{16'd65535, 5'd0, 16'd65535, 16'hFFFF});
    pending_q.push_back('{16'd10000, 5'd17, 16'd40000, 16'd0});
    pending_q.push_back('{16'hFFFE, 5'd16, 16'hFFFF, 16'hFFFF});
    pending_q.push_back('{16'd1, 5'd0, 16'hFFFF, 16'hFFFF});
    pending_q.push_back('{16'd20000, 5'd18, 16'd1, 16'hFFFF});
  endtask

  initial begin
    supply = tvt_pkg::SUPPLY_RST;
    coef[0] = tvt_pkg::COEF_A_RST;
    coef[1] = tvt_pkg::COEF_B_RST;
    coef[2] = tvt_pkg::COEF_C_RST;
    coef[3] = tvt_pkg::COEF_D_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    directed();
    drain();
    send_idle_pct = 6;
    recv_idle_pct = 85;
    random_phase(150);
    hold_cycles = 300;
    drain();
    send_idle_pct = 85;
    recv_idle_pct = 6;
    random_phase(100);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(150);
    drain();
    // zero denominator, negative denominator, extreme coefficients
    write_reg(tvt_pkg::REG_COEF_A, 48'h0);
    write_reg(tvt_pkg::REG_COEF_B, 48'h0);
    write_reg(tvt_pkg::REG_COEF_C, 48'h0);
    write_reg(tvt_pkg::REG_COEF_D, 48'h0);
    write_reg(3'd7, 48'h123);
    random_phase(10);
    drain();
    write_reg(tvt_pkg::REG_COEF_A, 48'h8000_0000_0000);
    write_reg(tvt_pkg::REG_COEF_D, 48'h7FFF_FFFF_FFFF);
    write_reg(tvt_pkg::REG_SUPPLY, 16'hFFFF);
    random_phase(40);
    drain();
    write_reg(tvt_pkg::REG_COEF_A, 48'h7FFF_FFFF_FFFF);
    write_reg(tvt_pkg::REG_COEF_B, 48'h8000_0000_0000);
    write_reg(tvt_pkg::REG_COEF_C, 48'h7FFF_FFFF_FFFF);
    write_reg(tvt_pkg::REG_COEF_D, 48'h8000_0000_0000);
    write_reg(tvt_pkg::REG_SUPPLY, 16'd1);
    random_phase(40);
    drain();
    write_reg(tvt_pkg::REG_SUPPLY, 16'd50000);
    write_reg(tvt_pkg::REG_COEF_A, 48'd1000000000);
    write_reg(tvt_pkg::REG_COEF_B, tvt_pkg::COEF_B_RST);
    write_reg(tvt_pkg::REG_COEF_C, tvt_pkg::COEF_C_RST);
    write_reg(tvt_pkg::REG_COEF_D, tvt_pkg::COEF_D_RST);
    send_idle_pct = 20;
    recv_idle_pct = 20;
    random_phase(80);
    drain();
    $display("%0d results checked, %0d faults, over reset and extreme coefficient sets",
             results, faults);
    if (errors == 0) begin
      $display("thermistor_voltage_to_temperature_core verification clean");
    end else begin
      $display("thermistor_voltage_to_temperature_core verification failed");
    end
    $finish;
  end

endmodule
